### sv/cus_pkg.sv
// ----------------------------------------------------------------------------
// cus_pkg
// Shared default width and the request class passed from front end to back end.
// ----------------------------------------------------------------------------
package cus_pkg;
    localparam int TIME_WIDTH_DEF = 64;

    typedef enum logic [1:0] {
        CLS_HOLD   = 2'd0,
        CLS_USER   = 2'd1,
        CLS_SYSTEM = 2'd2,
        CLS_DIVIDE = 2'd3
    } cls_t;
endpackage

### sv/cus_front.sv
// ----------------------------------------------------------------------------
// cus_front
// Registers each request and classifies it by the previous sum and the
// sampled times.
// ----------------------------------------------------------------------------
module cus_front import cus_pkg::*; #(
    parameter int TW = TIME_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [TW-1:0] total_runtime,
    input  logic [TW-1:0] sampled_system,
    input  logic [TW-1:0] sampled_user,
    input  logic [TW-1:0] prev_system_time,
    input  logic [TW-1:0] prev_user_time,
    output logic          f_valid,
    output cls_t          f_cls,
    output logic [TW-1:0] f_rt,
    output logic [TW-1:0] f_ss,
    output logic [TW-1:0] f_su,
    output logic [TW-1:0] f_ps,
    output logic [TW-1:0] f_pu
);
    logic    [TW:0] psum;
    cls_t           cls_next;
    logic           valid_reg;
    cls_t           cls_reg;
    logic  [TW-1:0] rt_reg, ss_reg, su_reg, ps_reg, pu_reg;

    assign psum = {1'b0, prev_system_time} + {1'b0, prev_user_time};

    always_comb
    begin
        if (psum >= {1'b0, total_runtime})
            cls_next = CLS_HOLD;
        else if (sampled_system == '0)
            cls_next = CLS_USER;
        else if (sampled_user == '0)
            cls_next = CLS_SYSTEM;
        else
            cls_next = CLS_DIVIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cls_reg <= cls_next;
            rt_reg  <= total_runtime;
            ss_reg  <= sampled_system;
            su_reg  <= sampled_user;
            ps_reg  <= prev_system_time;
            pu_reg  <= prev_user_time;
        end
    end

    assign f_valid = valid_reg;
    assign f_cls   = cls_reg;
    assign f_rt    = rt_reg;
    assign f_ss    = ss_reg;
    assign f_su    = su_reg;
    assign f_ps    = ps_reg;
    assign f_pu    = pu_reg;
endmodule

### sv/cus_back.sv
// ----------------------------------------------------------------------------
// cus_back
// Pipelined multiply, restoring divide (one quotient bit per stage) and
// monotonic clamp. Accepts one request per cycle.
// ----------------------------------------------------------------------------
module cus_back import cus_pkg::*; #(
    parameter int TW = TIME_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  cls_t          in_cls,
    input  logic [TW-1:0] in_rt,
    input  logic [TW-1:0] in_ss,
    input  logic [TW-1:0] in_su,
    input  logic [TW-1:0] in_ps,
    input  logic [TW-1:0] in_pu,
    output logic          done,
    output logic [TW-1:0] user_time,
    output logic [TW-1:0] system_time,
    output logic          updated
);
    localparam int HW = TW / 2;
    localparam int LW = TW - HW;
    localparam int PW = 2 * LW;
    localparam int NS = TW;

    // Stage 1: four partial products, each about half by half.
    logic          v1_reg;
    cls_t          c1_reg;
    logic [TW-1:0] rt1_reg, ps1_reg, pu1_reg;
    logic [TW:0]   d1_reg;
    logic [PW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        c1_reg  <= in_cls;
        rt1_reg <= in_rt;
        ps1_reg <= in_ps;
        pu1_reg <= in_pu;
        d1_reg  <= {1'b0, in_ss} + {1'b0, in_su};
        p00_reg <= {{LW{1'b0}}, in_ss[LW-1:0]} * {{LW{1'b0}}, in_rt[LW-1:0]};
        p01_reg <= {{(PW-HW){1'b0}}, in_ss[TW-1:LW]} * {{LW{1'b0}}, in_rt[LW-1:0]};
        p10_reg <= {{LW{1'b0}}, in_ss[LW-1:0]} * {{(PW-HW){1'b0}}, in_rt[TW-1:LW]};
        p11_reg <= {{(PW-HW){1'b0}}, in_ss[TW-1:LW]}
                 * {{(PW-HW){1'b0}}, in_rt[TW-1:LW]};
    end

    // Stage 2: sum partial products into the full product.
    logic          v2_reg;
    cls_t          c2_reg;
    logic [TW-1:0] rt2_reg, ps2_reg, pu2_reg;
    logic [TW:0]   d2_reg;
    logic [2*TW-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        c2_reg   <= c1_reg;
        rt2_reg  <= rt1_reg;
        ps2_reg  <= ps1_reg;
        pu2_reg  <= pu1_reg;
        d2_reg   <= d1_reg;
        prod_reg <= {{(2*TW-PW){1'b0}}, p00_reg}
                  + ({{(2*TW-PW){1'b0}}, p01_reg} << LW)
                  + ({{(2*TW-PW){1'b0}}, p10_reg} << LW)
                  + ({{(2*TW-PW){1'b0}}, p11_reg} << (2 * LW));
    end

    // Divider stages. The quotient fits in TW bits (it never exceeds the
    // runtime), so the top TW bits of the product seed the partial remainder.
    logic          vs_reg  [NS+1];
    cls_t          cs_reg  [NS+1];
    logic [TW-1:0] rts_reg [NS+1];
    logic [TW-1:0] pss_reg [NS+1];
    logic [TW-1:0] pus_reg [NS+1];
    logic [TW:0]   ds_reg  [NS+1];
    logic [TW:0]   rem_reg [NS+1];
    logic [TW-1:0] num_reg [NS+1];
    logic [TW-1:0] q_reg   [NS+1];

    always_comb
    begin
        vs_reg[0]  = v2_reg;
        cs_reg[0]  = c2_reg;
        rts_reg[0] = rt2_reg;
        pss_reg[0] = ps2_reg;
        pus_reg[0] = pu2_reg;
        ds_reg[0]  = d2_reg;
        rem_reg[0] = {1'b0, prod_reg[2*TW-1:TW]};
        num_reg[0] = prod_reg[TW-1:0];
        q_reg[0]   = '0;
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_div
        logic [TW+1:0] sh;
        logic [TW+1:0] diff;
        assign sh   = {rem_reg[s], num_reg[s][TW-1]};
        assign diff = sh - {1'b0, ds_reg[s]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vs_reg[s+1] <= 1'b0;
            else
                vs_reg[s+1] <= vs_reg[s];
        end

        always_ff @(posedge clk)
        begin
            cs_reg[s+1]  <= cs_reg[s];
            rts_reg[s+1] <= rts_reg[s];
            pss_reg[s+1] <= pss_reg[s];
            pus_reg[s+1] <= pus_reg[s];
            ds_reg[s+1]  <= ds_reg[s];
            num_reg[s+1] <= {num_reg[s][TW-2:0], 1'b0};
            if (!diff[TW+1])
            begin
                rem_reg[s+1] <= diff[TW:0];
                q_reg[s+1]   <= {q_reg[s][TW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= sh[TW:0];
                q_reg[s+1]   <= {q_reg[s][TW-2:0], 1'b0};
            end
        end
    end

    // Clamp stage 1: select raw system time and raise to the previous value.
    logic          va_reg;
    logic          hold_a_reg;
    logic [TW-1:0] sta_reg, rta_reg, pua_reg, psa_reg;
    logic [TW-1:0] st_raw;

    always_comb
    begin
        case (cs_reg[NS])
            CLS_USER:   st_raw = '0;
            CLS_SYSTEM: st_raw = rts_reg[NS];
            CLS_DIVIDE: st_raw = q_reg[NS];
            default:    st_raw = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= vs_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        hold_a_reg <= (cs_reg[NS] == CLS_HOLD);
        sta_reg    <= (st_raw < pss_reg[NS]) ? pss_reg[NS] : st_raw;
        rta_reg    <= rts_reg[NS];
        pua_reg    <= pus_reg[NS];
        psa_reg    <= pss_reg[NS];
    end

    // Clamp stage 2: derive user time and apply the user clamp, or keep the previous pair when held.
    logic          done_reg, upd_reg;
    logic [TW-1:0] ut_reg, st_reg;
    logic [TW-1:0] ut_c;

    assign ut_c = rta_reg - sta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        upd_reg <= !hold_a_reg;
        if (hold_a_reg)
        begin
            ut_reg <= pua_reg;
            st_reg <= psa_reg;
        end
        else if (ut_c < pua_reg)
        begin
            ut_reg <= pua_reg;
            st_reg <= rta_reg - pua_reg;
        end
        else
        begin
            ut_reg <= ut_c;
            st_reg <= sta_reg;
        end
    end

    assign done        = done_reg;
    assign user_time   = ut_reg;
    assign system_time = st_reg;
    assign updated     = upd_reg;

    a_upd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !upd_reg |-> ut_reg == $past(pua_reg))
        else $error("held pair does not match previous user time");
    a_mono_user: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && upd_reg |-> ut_reg >= $past(pua_reg))
        else $error("user time went backwards");
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg |=> done_reg)
        else $error("clamp stage lost a request");
endmodule

### sv/cputime_user_system_split_top.sv
// ----------------------------------------------------------------------------
// cputime_user_system_split_top
// Splits total runtime into monotonic user and system parts.
// ----------------------------------------------------------------------------
// A new request is taken every cycle (busy is always low). Each result
// passes through the front register, a two-stage multiplier, the
// one-bit-per-stage divider pipeline and a two-stage clamp. done pulses
// for one cycle with the result; the receiver cannot stall, and results
// leave in request order.
module cputime_user_system_split_top import cus_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TIME_WIDTH-1:0] total_runtime,
    input  logic [TIME_WIDTH-1:0] sampled_system,
    input  logic [TIME_WIDTH-1:0] sampled_user,
    input  logic [TIME_WIDTH-1:0] prev_system_time,
    input  logic [TIME_WIDTH-1:0] prev_user_time,
    output logic                  done,
    output logic [TIME_WIDTH-1:0] user_time,
    output logic [TIME_WIDTH-1:0] system_time,
    output logic                  updated
);
    logic                  f_valid;
    cls_t                  f_cls;
    logic [TIME_WIDTH-1:0] f_rt, f_ss, f_su, f_ps, f_pu;

    assign busy = 1'b0;

    cus_front #(.TW(TIME_WIDTH)) u_front (
        .clk, .rst_n, .start,
        .total_runtime, .sampled_system, .sampled_user,
        .prev_system_time, .prev_user_time,
        .f_valid, .f_cls, .f_rt, .f_ss, .f_su, .f_ps, .f_pu
    );

    cus_back #(.TW(TIME_WIDTH)) u_back (
        .clk, .rst_n,
        .in_valid(f_valid), .in_cls(f_cls), .in_rt(f_rt), .in_ss(f_ss),
        .in_su(f_su), .in_ps(f_ps), .in_pu(f_pu),
        .done, .user_time, .system_time, .updated
    );
endmodule

### bench/cputime_user_system_split_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cputime_user_system_split_top_tb
// Drives task time records into the runtime splitter and compares every
// user/system pair against a predictor built on exact wide arithmetic,
// under several sender idling phases.
// ----------------------------------------------------------------------------
module cputime_user_system_split_top_tb;
    import cus_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;
    localparam int LATENCY = TW + 5;

    typedef logic [TW-1:0] time_t;

    typedef struct packed {
        time_t user_part;
        time_t system_part;
        logic  fresh;
    } split_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    time_t total_runtime;
    time_t sampled_system;
    time_t sampled_user;
    time_t prev_system_time;
    time_t prev_user_time;
    logic  done;
    time_t user_time;
    time_t system_time;
    logic  updated;

    split_t pending_splits[$];
    int     fail_count;
    int     idle_pct;

    cputime_user_system_split_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .total_runtime    (total_runtime),
        .sampled_system   (sampled_system),
        .sampled_user     (sampled_user),
        .prev_system_time (prev_system_time),
        .prev_user_time   (prev_user_time),
        .done             (done),
        .user_time        (user_time),
        .system_time      (system_time),
        .updated          (updated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    function automatic split_t predict_split(time_t rt, time_t ss, time_t su,
                                             time_t ps, time_t pu);
        split_t         r;
        logic [TW:0]    prev_sum;
        logic [TW:0]    divisor;
        logic [2*TW:0]  product;
        logic [2*TW:0]  quotient;
        time_t          sys_part;
        time_t          usr_part;
        prev_sum = {1'b0, ps} + {1'b0, pu};
        if (prev_sum >= {1'b0, rt})
        begin
            r.user_part   = pu;
            r.system_part = ps;
            r.fresh       = 1'b0;
            return r;
        end
        if (ss == '0)
            sys_part = '0;
        else if (su == '0)
            sys_part = rt;
        else
        begin
            divisor  = {1'b0, ss} + {1'b0, su};
            product  = {{(TW+1){1'b0}}, ss} * {{(TW+1){1'b0}}, rt};
            quotient = product / {{TW{1'b0}}, divisor};
            sys_part = quotient[TW-1:0];
        end
        if (sys_part < ps)
            sys_part = ps;
        usr_part = rt - sys_part;
        if (usr_part < pu)
        begin
            usr_part = pu;
            sys_part = rt - usr_part;
        end
        r.user_part   = usr_part;
        r.system_part = sys_part;
        r.fresh       = 1'b1;
        return r;
    endfunction

    // Checker: every done pulse must match the oldest prediction.
    always @(posedge clk)
    begin
        split_t exp_s;
        if (rst_n && done)
        begin
            if (pending_splits.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                exp_s = pending_splits.pop_front();
                if (user_time !== exp_s.user_part)
                begin
                    $error("user_time expected %0h actual %0h", exp_s.user_part, user_time);
                    fail_count++;
                end
                if (system_time !== exp_s.system_part)
                begin
                    $error("system_time expected %0h actual %0h",
                           exp_s.system_part, system_time);
                    fail_count++;
                end
                if (updated !== exp_s.fresh)
                begin
                    $error("updated expected %0b actual %0b", exp_s.fresh, updated);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(time_t rt, time_t ss, time_t su, time_t ps, time_t pu);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start            <= 1'b1;
        total_runtime    <= rt;
        sampled_system   <= ss;
        sampled_user     <= su;
        prev_system_time <= ps;
        prev_user_time   <= pu;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_splits.push_back(predict_split(rt, ss, su, ps, pu));
    endtask

    task automatic end_requests();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic time_t rand_time();
        time_t v;
        v = {$urandom, $urandom};
        case ($urandom_range(5, 0))
            0: v = '0;
            1: v = '1;
            2: v = v >> $urandom_range(TW - 1, 0);
            3: v = TW'($urandom_range(1000, 1));
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        time_t mx;
        mx = '1;
        send_request('0, '0, '0, '0, '0);
        send_request(mx, mx, mx, '0, '0);
        send_request(mx, mx, '0, '0, '0);
        send_request(mx, '0, mx, '0, '0);
        send_request(mx, '0, '0, '0, '0);
        send_request(1000, 3, 1, 0, 0);
        send_request(1000, 1, 3, 0, 0);
        // Previous pair already covers the runtime, including an overflowing sum.
        send_request(1000, 5, 5, 600, 400);
        send_request(1000, 5, 5, 700, 400);
        send_request(5, 1, 1, mx, mx);
        send_request(mx, 1, 1, mx, 1);
        // Clamp to previous system, then previous user wins.
        send_request(1000, 1, 9, 300, 10);
        send_request(1000, 9, 1, 10, 300);
        send_request(1000, 1, 1, 499, 499);
        send_request(mx, mx, 1, '0, mx - 1);
        send_request(mx, 1, mx, mx - 1, '0);
        send_request(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                     64'h5555_5555_5555_5555, 64'h1, 64'h2);
        send_request(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                     64'haaaa_aaaa_aaaa_aaaa, 64'h2, 64'h1);
        end_requests();
    endtask

    task automatic test_random(int count, int pct);
        time_t rt;
        time_t ps;
        time_t pu;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            rt = rand_time();
            // Mostly keep the previous pair below the runtime so the split runs.
            if ($urandom_range(3, 0) != 0 && rt != '0)
            begin
                ps = {$urandom, $urandom} % rt;
                pu = {$urandom, $urandom} % (rt - ps);
            end
            else
            begin
                ps = rand_time();
                pu = rand_time();
            end
            send_request(rt, rand_time(), rand_time(), ps, pu);
        end
        end_requests();
        idle_pct = 0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_splits.size() != 0 && guard < 10 * LATENCY)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    initial
    begin
        fail_count       = 0;
        idle_pct         = 0;
        rst_n            = 1'b0;
        start            = 1'b0;
        total_runtime    = '0;
        sampled_system   = '0;
        sampled_user     = '0;
        prev_system_time = '0;
        prev_user_time   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300, 0);
        test_random(200, 61);
        test_random(150, 27);
        test_random(200, 0);
        drain();

        if (fail_count == 0 && pending_splits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
